/* hdl/chme_pkg.sv */
// Shared types and constants of the chained hash map engine.
package chme_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 9;
  localparam int CMD_W = 2;
  localparam int STS_W = 2;
  localparam int DIVIDEND_W = 64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STS_W-1:0] STS_UPDATED   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_WALK,
    ST_DECIDE
  } state_t;

endpackage

/* hdl/chained_hash_map_engine_top.sv */
// Top level of the chained hash map engine: command decode, modulo unit and table walk.
//
// Channel | Ports                                   | Handshake
// command | in_command, in_key, in_value            | start high while busy is low
// result  | out_status, out_read_value              | out_valid strobe, one cycle
// config  | cfg_data                                | cfg_valid and cfg_ready
//
// After a command beat the block stays busy through a restoring modulo of the
// sign-extended key, a setup step, the walk (one read per way, one step for the
// last read's data, one to let the pipe empty) and a decision step. The result
// strobe comes in the cycle after the decision, when the next beat can already be
// taken; a new command is taken only once the last one is through. After reset the
// block sweeps the valid memory, one entry a cycle, with busy high; the receiver cannot stall.
module chained_hash_map_engine_top #(
  parameter int BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [chme_pkg::CMD_W-1:0] in_command,
  input  logic signed [chme_pkg::KEY_W-1:0] in_key,
  input  logic signed [chme_pkg::VAL_W-1:0] in_value,
  output logic                     out_valid,
  output logic [chme_pkg::STS_W-1:0] out_status,
  output logic signed [chme_pkg::VAL_W-1:0] out_read_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [chme_pkg::CFG_W-1:0] cfg_data
);
  import chme_pkg::*;

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W = $clog2(WAYS + 1);
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int REM_W = CFG_W + 1 > BKT_W + 1 ? CFG_W + 1 : BKT_W + 1;
  localparam int BIT_W = 6;
  localparam int ECNT_W = $clog2(ENTRIES + 1);

  // Three memories share one write address and one read address; the valid memory is swept after reset.
  logic             mem_valid [ENTRIES];
  logic [KEY_W-1:0] mem_key   [ENTRIES];
  logic [VAL_W-1:0] mem_value [ENTRIES];

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  cfg_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [REM_W-1:0]  divisor_r;
  logic [BIT_W-1:0]  bit_r;
  logic [IDX_W-1:0]  base_r;
  logic [WCNT_W-1:0] way_r;      // way whose read is issued
  logic [WCNT_W-1:0] rway_r;     // way whose data returns
  logic              rd_pend_r;
  logic              found_r, free_r;
  logic [WAY_W-1:0]  hit_r, freew_r;
  logic [VAL_W-1:0]  hit_val_r;
  logic [ECNT_W-1:0] clr_r;

  logic             rd_valid_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_value_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic             wr_valid;
  logic             wr_kv;

  logic [DIVIDEND_W-1:0] dividend;
  logic [REM_W-1:0]      shifted;
  logic [CFG_W-1:0]      eff;

  // Out-of-range counts fold to the nearest legal one.
  always_comb begin
    if (cfg_r == '0) begin
      eff = CFG_W'(1);
    end else if (32'(cfg_r) > 32'(BUCKETS)) begin
      eff = CFG_W'(BUCKETS);
    end else begin
      eff = cfg_r;
    end
  end

  assign dividend = {{(DIVIDEND_W-KEY_W){key_r[KEY_W-1]}}, key_r};
  assign shifted = {rem_r[REM_W-2:0], dividend[bit_r]};
  assign rem_nxt = (shifted >= divisor_r) ? shifted - divisor_r : shifted;

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign rd_idx = base_r + IDX_W'(way_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cfg_r <= CFG_W'(256);
      clr_r <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ECNT_W'(1);
      end
      rd_pend_r <= (state_r == ST_WALK) && (32'(way_r) < WAYS);
      if (state_r == ST_DECIDE) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_r <= in_command;
          key_r <= in_key;
          val_r <= in_value;
          rem_r <= '0;
          divisor_r <= REM_W'(eff);
          bit_r <= BIT_W'(DIVIDEND_W - 1);
        end
      end
      ST_DIVIDE: begin
        rem_r <= rem_nxt;
        bit_r <= bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          base_r <= IDX_W'(32'(rem_nxt) * WAYS);
        end
      end
      ST_READ: begin
        way_r <= '0;
        rway_r <= '0;
        found_r <= 1'b0;
        free_r <= 1'b0;
      end
      ST_WALK: begin
        if (32'(way_r) < WAYS) begin
          way_r <= way_r + WCNT_W'(1);
        end
        if (rd_pend_r) begin
          rway_r <= rway_r + WCNT_W'(1);
          if (rd_valid_r) begin
            if (!found_r && rd_key_r == key_r) begin
              found_r <= 1'b1;
              hit_r <= WAY_W'(rway_r);
              hit_val_r <= rd_value_r;
            end
          end else if (!free_r) begin
            free_r <= 1'b1;
            freew_r <= WAY_W'(rway_r);
          end
        end
      end
      ST_DECIDE: begin
        out_read_value <= '0;
        out_status <= STS_NOT_FOUND;
        case (cmd_r)
          CMD_INSERT: begin
            if (found_r) out_status <= STS_UPDATED;
            else if (free_r) out_status <= STS_DONE;
            else out_status <= STS_FULL;
          end
          CMD_LOOKUP: begin
            if (found_r) begin
              out_status <= STS_DONE;
              out_read_value <= hit_val_r;
            end
          end
          CMD_DELETE: begin
            if (found_r) out_status <= STS_DONE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Write-back decision; reads finish before any write, so no forwarding is needed.
  always_comb begin
    wr_en = 1'b0;
    wr_kv = 1'b0;
    wr_valid = 1'b0;
    wr_idx = base_r + IDX_W'(hit_r);
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
      wr_idx = IDX_W'(clr_r);
    end else if (state_r == ST_DECIDE) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (found_r) begin
            wr_kv = 1'b1;
          end else if (free_r) begin
            wr_idx = base_r + IDX_W'(freew_r);
            wr_en = 1'b1;
            wr_valid = 1'b1;
            wr_kv = 1'b1;
          end
        end
        CMD_DELETE: begin
          wr_en = found_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_idx] <= wr_valid;
    end
    if (wr_kv) begin
      mem_key[wr_idx] <= key_r;
      mem_value[wr_idx] <= val_r;
    end
    rd_valid_r <= mem_valid[rd_idx];
    rd_key_r <= mem_key[rd_idx];
    rd_value_r <= mem_value[rd_idx];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (32'(clr_r) == ENTRIES - 1) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (bit_r == '0) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_WALK;
      ST_WALK:   if (32'(way_r) == WAYS && !rd_pend_r) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* dv/tb_chained_hash_map_engine_top.sv */
// Self-checking testbench of the chained hash map engine: commands, table model, result check.
`timescale 1ns / 1ps

module tb_chained_hash_map_engine_top;
  import chme_pkg::*;

  localparam int BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int ENTRIES = BUCKETS * WAYS;
  // Long enough for the block to finish one more command.
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS = 500;
  // Command code 3 has no meaning; the block answers it with not found.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } command_beat_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] read_value;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_command = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic [STS_W-1:0] out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  chained_hash_map_engine_top #(.BUCKETS(BUCKETS), .WAYS(WAYS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status), .out_read_value(out_read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table and of the bucket count register.
  logic             table_valid [ENTRIES];
  logic [KEY_W-1:0] table_key   [ENTRIES];
  logic [VAL_W-1:0] table_value [ENTRIES];
  logic [CFG_W-1:0] shadow_bucket_count;

  command_beat_t pending_commands[$];
  result_beat_t  expected_results[$];
  int mismatch_count = 0;
  bit quiet_phase = 1'b0;
  bit hold_commands = 1'b0;

  // The bucket is the sign-extended key modulo the bucket count in use, where a
  // count of zero acts as one and anything above the table size is clamped.
  function automatic int unsigned bucket_base_of(logic [KEY_W-1:0] key);
    logic [DIVIDEND_W-1:0] pattern;
    logic [DIVIDEND_W-1:0] divisor;
    pattern = {{(DIVIDEND_W-KEY_W){key[KEY_W-1]}}, key};
    if (shadow_bucket_count == 0) divisor = 1;
    else if (shadow_bucket_count > BUCKETS) divisor = BUCKETS;
    else divisor = shadow_bucket_count;
    return int'(pattern % divisor) * WAYS;
  endfunction

  // Applies one accepted command to the shadow table and returns its result.
  function automatic result_beat_t apply_table_command(command_beat_t cmd);
    result_beat_t res;
    int unsigned base;
    int hit;
    int free_slot;
    base = bucket_base_of(cmd.key);
    hit = -1;
    free_slot = -1;
    res.status = STS_NOT_FOUND;
    res.read_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (base + w < ENTRIES) begin
        if (table_valid[base + w]) begin
          if (hit < 0 && table_key[base + w] == cmd.key) hit = base + w;
        end else if (free_slot < 0) begin
          free_slot = base + w;
        end
      end
    end
    case (cmd.command)
      CMD_INSERT: begin
        if (hit >= 0) begin
          table_value[hit] = cmd.value;
          res.status = STS_UPDATED;
        end else if (free_slot >= 0) begin
          table_valid[free_slot] = 1'b1;
          table_key[free_slot] = cmd.key;
          table_value[free_slot] = cmd.value;
          res.status = STS_DONE;
        end else begin
          res.status = STS_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (hit >= 0) begin
          res.status = STS_DONE;
          res.read_value = table_value[hit];
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          table_valid[hit] = 1'b0;
          res.status = STS_DONE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Driver: presents the head of the queue at the falling edge and takes it off
  // once a rising edge has seen start high with busy low. Random idle bursts
  // hold start low, counting down only while the block is free, except in the
  // quiet phase.
  int idle_left = 0;
  bit beat_taken;

  always @(posedge clk) begin
    beat_taken <= rst_n && start && !busy;
  end

  always @(negedge clk) begin
    if (beat_taken) begin
      void'(pending_commands.pop_front());
    end
    if (idle_left > 0) begin
      if (!busy) idle_left <= idle_left - 1;
      start <= 1'b0;
    end else if (pending_commands.size() > 0 && !hold_commands && rst_n) begin
      command_beat_t next_cmd;
      next_cmd = pending_commands[0];
      if (!quiet_phase && (beat_taken || !start) && $urandom_range(0, 5) == 0) begin
        idle_left <= beat_taken ? $urandom_range(1, 7) : $urandom_range(0, 6);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_command <= next_cmd.command;
        in_key <= next_cmd.key;
        in_value <= next_cmd.value;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: a command beat updates the prediction, a result beat is compared
  // with the oldest expected result.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      command_beat_t cmd;
      cmd.command = in_command;
      cmd.key = in_key;
      cmd.value = in_value;
      expected_results.push_back(apply_table_command(cmd));
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d read_value %0d", out_status, out_read_value);
      end else begin
        result_beat_t want;
        want = expected_results.pop_front();
        if (out_status !== want.status || out_read_value !== want.read_value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected status %0d value %0d, got status %0d value %0d",
                     want.status, $signed(want.read_value), out_status, out_read_value);
        end
      end
    end
  end

  task automatic queue_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
    command_beat_t beat;
    beat.command = cmd;
    beat.key = key;
    beat.value = value;
    pending_commands.push_back(beat);
  endtask

  // Waits until all commands are taken and all results are in, then lets the
  // block finish anything still in flight.
  task automatic drain_all();
    while (pending_commands.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the bucket count; only done while the block is idle.
  task automatic write_bucket_count(logic [CFG_W-1:0] count);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    shadow_bucket_count = count;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keys are drawn from a small pool so that inserts, hits and full buckets
  // all happen often; now and then a fully random key is used.
  logic [KEY_W-1:0] key_pool [16];

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, 15)];
  endfunction

  task automatic queue_random_commands(int count);
    for (int i = 0; i < count; i++) begin
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9) queue_command(CMD_INSERT, pick_key(), $urandom);
      else if (pick < 15) queue_command(CMD_LOOKUP, pick_key(), $urandom);
      else if (pick < 19) queue_command(CMD_DELETE, pick_key(), $urandom);
      else queue_command(CMD_UNUSED, pick_key(), $urandom);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] counts [6];
    for (int i = 0; i < ENTRIES; i++) begin
      table_valid[i] = 1'b0;
      table_key[i] = '0;
      table_value[i] = '0;
    end
    shadow_bucket_count = 9'd256;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset bucket count; the table sweep after reset is
    // covered because the driver waits on busy.
    queue_command(CMD_LOOKUP, 32'h0000_0005, 32'h0);
    queue_command(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_command(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_command(CMD_LOOKUP, 32'h8000_0000, 32'h1234_5678);
    queue_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    // A present key is updated in place, not duplicated.
    queue_command(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    queue_command(CMD_DELETE, 32'h7FFF_FFFF, 32'h0);
    queue_command(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    queue_command(CMD_DELETE, 32'h7FFF_FFFF, 32'h0);
    // Filling one bucket: keys 3, 259, 515, 771 share bucket 3, the fifth is full.
    for (int i = 0; i < 5; i++)
      queue_command(CMD_INSERT, 32'(3 + 256 * i), 32'(i));
    queue_command(CMD_UNUSED, 32'h0000_0003, 32'hFFFF_FFFF);
    queue_command(CMD_LOOKUP, 32'h0000_0303, 32'h0);
    queue_command(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    drain_all();

    // The count takes in-range and out-of-range settings: zero acts as one,
    // anything past the table size is clamped.
    counts[0] = 9'd1;
    counts[1] = 9'd0;
    counts[2] = 9'd511;
    counts[3] = 9'd3;
    counts[4] = 9'd256;
    counts[5] = 9'd17;
    foreach (counts[c]) begin
      write_bucket_count(counts[c]);
      for (int k = 0; k < 16; k++) key_pool[k] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      if (c == 3) begin
        // Let everything so far come back, then hold the sender while more commands queue up.
        queue_random_commands(40);
        drain_all();
        hold_commands = 1'b1;
        queue_random_commands(40);
        repeat (20) @(posedge clk);
        hold_commands = 1'b0;
      end else begin
        queue_random_commands(RANDOM_ITEMS / 6);
      end
      if (c == 5) quiet_phase = 1'b1;
      drain_all();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Roughly 500 commands plus the sweep after reset; the limit is several
  // times the time they take.
  initial begin
    #800000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* chained_hash_map_engine_top.f */
hdl/chme_pkg.sv
hdl/chained_hash_map_engine_top.sv
dv/tb_chained_hash_map_engine_top.sv
